FILE: hdl/nde_pkg.sv
// ============================================================================
// nde_pkg
// Shared types and the nibble table for the nibble debias extractor.
// ============================================================================
package nde_pkg;

    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned NibbleWidth = 4;
    localparam int unsigned CountWidth  = 4;

    // Bits that one nibble contributes. bits[0] is appended first.
    typedef struct packed {
        logic [1:0] count;
        logic [1:0] bits;
    } t_nib_bits;

    // Result of handling one raw byte.
    typedef struct packed {
        logic                 emit;
        logic [ByteWidth-1:0] data;
    } t_acc_result;

    // Improved von Neumann table: a nibble is read as two bit pairs.
    function automatic t_nib_bits nibble_map(input logic [NibbleWidth-1:0] nib);
        t_nib_bits r;
        r = '{count: 2'd0, bits: 2'b00};
        case (nib) inside
            4'd3:               r = '{count: 2'd1, bits: 2'b00};
            4'd12:              r = '{count: 2'd1, bits: 2'b01};
            4'd1, 4'd5, 4'd13:  r = '{count: 2'd2, bits: 2'b00};
            4'd4, 4'd6, 4'd7:   r = '{count: 2'd2, bits: 2'b10};
            4'd2, 4'd9, 4'd14:  r = '{count: 2'd2, bits: 2'b01};
            4'd8, 4'd10, 4'd11: r = '{count: 2'd2, bits: 2'b11};
            default:            r = '{count: 2'd0, bits: 2'b00};
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/nde_accum.sv
// ============================================================================
// nde_accum
// Bit accumulator: appends the bits of both nibbles of a byte and reports a
// completed byte.
// ============================================================================
module nde_accum (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [nde_pkg::ByteWidth-1:0]   i_byte,
    input  logic                            i_last,
    output nde_pkg::t_acc_result            o_result
);

    logic [nde_pkg::CountWidth-1:0] r_bit_count;
    logic [nde_pkg::CountWidth-1:0] n_bit_count;
    logic [nde_pkg::ByteWidth-1:0]  r_partial;
    logic [nde_pkg::ByteWidth-1:0]  n_partial;

    always_comb begin
        logic [nde_pkg::CountWidth-1:0] cnt;
        logic [nde_pkg::ByteWidth-1:0]  part;
        nde_pkg::t_nib_bits             nb;
        cnt      = r_bit_count;
        part     = r_partial;
        o_result = '{emit: 1'b0, data: '0};
        for (int k = 0; k < 2; k++) begin
            nb = nde_pkg::nibble_map(i_byte[k*nde_pkg::NibbleWidth +: nde_pkg::NibbleWidth]);
            for (int i = 0; i < 2; i++) begin
                // A bit that would land past the top position is dropped.
                if ((2'(i) < nb.count) && !cnt[nde_pkg::CountWidth-1]) begin
                    if (nb.bits[i]) begin
                        part[cnt[nde_pkg::CountWidth-2:0]] = 1'b1;
                    end
                    cnt = cnt + 1'b1;
                end
            end
            if (cnt[nde_pkg::CountWidth-1]) begin
                o_result = '{emit: 1'b1, data: part};
                cnt      = '0;
                part     = '0;
            end
        end
        if (i_last) begin
            cnt  = '0;
            part = '0;
        end
        n_bit_count = cnt;
        n_partial   = part;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= '0;
            r_partial   <= '0;
        end else if (i_en) begin
            r_bit_count <= n_bit_count;
            r_partial   <= n_partial;
        end
    end

endmodule

FILE: hdl/nibble_debias_extractor.sv
// ============================================================================
// nibble_debias_extractor
// Improved von Neumann debiaser that turns raw entropy bytes into unbiased
// output bytes.
// ============================================================================
// Each raw byte is split into its low and then its high nibble, and every
// nibble yields zero, one or two unbiased bits, packed least significant bit
// first into a partial byte. A full byte is sent out on the master side; a
// bit that would fall past bit 7 is dropped. A slave transaction with tlast
// set marks the end of a block, and any partial byte left after it is
// discarded. The block takes one raw byte per clock cycle unless back pressure
// stalls it: a transaction is registered at the input, handled by the
// combinational accumulator, and the result byte sits in an output register
// from which it is sent as a master transaction. Back pressure on the master side stalls the
// input only when both registers are holding data.
module nibble_debias_extractor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [nde_pkg::ByteWidth-1:0] s_axis_tdata,   // [7:0] raw_byte
    input  logic                          s_axis_tlast,   // block_end
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [nde_pkg::ByteWidth-1:0] m_axis_tdata    // [7:0] random_byte
);

    // Input register.
    logic                          r_in_valid;
    logic [nde_pkg::ByteWidth-1:0] r_in_byte;
    logic                          r_in_last;

    // Output register.
    logic                          r_out_valid;
    logic [nde_pkg::ByteWidth-1:0] r_out_data;

    logic                 w_out_free;
    logic                 w_advance;
    nde_pkg::t_acc_result w_result;

    // The output register can take a new byte when it is empty or is being
    // drained in this cycle. The held input byte moves on whenever it can.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // The accumulator state changes only when the held byte is consumed.
    nde_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_result.emit) begin
            r_out_data <= w_result.data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
